[src/mrtu_pkg.sv]
// Shared types, constants and the CRC-16 byte step for the Modbus RTU poll master.
// Used by every module in src except mrtu_ram; depends on nothing else.
package mrtu_pkg;

  localparam int STORE_BYTES_DEF = 32;
  localparam int REGISTER_COUNT  = 8;
  localparam int RESP_LEN        = 5 + 2 * REGISTER_COUNT;
  localparam int EXC_LEN         = 5;

  localparam logic [7:0] FN_READ   = 8'h03;
  localparam logic [7:0] FN_EXCEPT = 8'h83;
  localparam logic [7:0] BYTE_COUNT = 8'(2 * REGISTER_COUNT);

  localparam logic [2:0] KIND_TX      = 3'd0;
  localparam logic [2:0] KIND_REFUSED = 3'd1;
  localparam logic [2:0] KIND_FRESH   = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_BAD     = 3'd4;

  localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_FIRST_REGISTER = 2'd1;
  localparam logic [1:0] CFG_DEADLINE_MS    = 2'd2;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;
  localparam logic [1:0] MODE_ABORT = 2'd3;

  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_CHECK,
    OP_ABORT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/mrtu_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the received frame bytes; no dependencies.
module mrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mrtu_front.sv]
// Input side: accepts stream items, classifies the mode and queues them.
// Depends on mrtu_pkg; feeds mrtu_back through a two-entry queue.
module mrtu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 q_valid,
  output mrtu_pkg::item_t      q_item,
  input  logic                 q_pop
);

  mrtu_pkg::item_t slot [2];
  logic [1:0]      count;
  logic            rd_ptr;
  logic            wr_ptr;
  logic            push;
  mrtu_pkg::item_t incoming;

  always_comb begin
    incoming.rx_byte = s_tdata[7:0];
    incoming.now_ms  = s_tdata[39:8];
    case (s_tuser)
      mrtu_pkg::MODE_START: incoming.op = mrtu_pkg::OP_START;
      mrtu_pkg::MODE_BYTE:  incoming.op = mrtu_pkg::OP_BYTE;
      mrtu_pkg::MODE_CHECK: incoming.op = mrtu_pkg::OP_CHECK;
      default:              incoming.op = mrtu_pkg::OP_ABORT;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= incoming;
        wr_ptr       <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

[src/mrtu_back.sv]
// Transaction engine: request generation, circular frame buffer, parser with
// resync and CRC walk, deadline test and the output register. Uses mrtu_pkg, mrtu_ram.
module mrtu_back #(
  parameter int STORE_BYTES = mrtu_pkg::STORE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  input  mrtu_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [167:0]       m_tdata,
  output logic [2:0]         m_tuser,
  output logic               m_tlast
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int LW = $clog2(STORE_BYTES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_REFUSE, S_TX,
    S_P0, S_A_REQ, S_A_USE,
    S_RS_REQ, S_RS_USE,
    S_F_REQ, S_F_USE, S_C_REQ, S_C_USE,
    S_K_REQ, S_K_USE, S_L_REQ, S_L_USE, S_H_REQ, S_H_USE,
    S_BUSY, S_VERD
  } state_t;

  state_t       st;
  logic [7:0]   slave_address;
  logic [15:0]  first_register;
  logic [15:0]  deadline_ms;
  logic [AW-1:0] base;
  logic [LW-1:0] len;
  logic [LW-1:0] off;
  logic         awaiting;
  logic         bad_seen;
  logic [31:0]  request_time;
  logic [31:0]  last_byte_time;
  logic [31:0]  cur_now;
  logic [15:0]  crc;
  logic [7:0]   lo_byte;
  logic [127:0] regs;
  logic [2:0]   verdict;
  logic [2:0]   tx_k;

  logic [LW:0]   rsum;
  logic [LW:0]   wsum;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  logic [7:0]    dout;
  logic          out_free;
  logic          out_load;
  logic          exp_now;
  logic          exp_lbt;
  logic [7:0]    req_byte;

  always_comb begin
    rsum = (LW+1)'(base) + (LW+1)'(off);
    if (rsum >= (LW+1)'(STORE_BYTES)) begin
      rsum = rsum - (LW+1)'(STORE_BYTES);
    end
    wsum = (LW+1)'(base) + (LW+1)'(len);
    if (wsum >= (LW+1)'(STORE_BYTES)) begin
      wsum = wsum - (LW+1)'(STORE_BYTES);
    end
  end

  assign raddr = rsum[AW-1:0];
  assign waddr = wsum[AW-1:0];
  assign we = (st == S_IDLE) && q_valid && (q_item.op == mrtu_pkg::OP_BYTE) && awaiting &&
              (len < LW'(STORE_BYTES));
  assign q_pop = (st == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (st == S_REFUSE || st == S_TX || st == S_VERD);
  assign exp_now = (cur_now - request_time) >= {16'h0000, deadline_ms};
  assign exp_lbt = (last_byte_time - request_time) >= {16'h0000, deadline_ms};

  always_comb begin
    case (tx_k)
      3'd0:    req_byte = slave_address;
      3'd1:    req_byte = mrtu_pkg::FN_READ;
      3'd2:    req_byte = first_register[15:8];
      3'd3:    req_byte = first_register[7:0];
      3'd4:    req_byte = 8'((mrtu_pkg::REGISTER_COUNT >> 8) & 255);
      3'd5:    req_byte = 8'(mrtu_pkg::REGISTER_COUNT & 255);
      3'd6:    req_byte = crc[7:0];
      default: req_byte = crc[15:8];
    endcase
  end

  mrtu_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_item.rx_byte),
    .raddr (raddr),
    .rdata (dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      slave_address  <= 8'd1;
      first_register <= 16'd0;
      deadline_ms    <= 16'd35;
      base           <= '0;
      len            <= '0;
      off            <= '0;
      awaiting       <= 1'b0;
      bad_seen       <= 1'b0;
      request_time   <= 32'd0;
      last_byte_time <= 32'd0;
      m_tvalid       <= 1'b0;
      tx_k           <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mrtu_pkg::CFG_SLAVE_ADDRESS:  slave_address  <= cfg_data[7:0];
          mrtu_pkg::CFG_FIRST_REGISTER: first_register <= cfg_data;
          mrtu_pkg::CFG_DEADLINE_MS:    deadline_ms    <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      case (st)
        S_IDLE: begin
          if (q_valid) begin
            cur_now <= q_item.now_ms;
            case (q_item.op)
              mrtu_pkg::OP_START: begin
                if (awaiting) begin
                  st <= S_REFUSE;
                end else begin
                  awaiting       <= 1'b1;
                  len            <= '0;
                  bad_seen       <= 1'b0;
                  request_time   <= q_item.now_ms;
                  last_byte_time <= q_item.now_ms;
                  crc            <= 16'hFFFF;
                  tx_k           <= 3'd0;
                  st             <= S_TX;
                end
              end
              mrtu_pkg::OP_ABORT: begin
                awaiting <= 1'b0;
                len      <= '0;
                bad_seen <= 1'b0;
              end
              default: begin
                if (awaiting) begin
                  if (we) begin
                    len            <= len + LW'(1);
                    last_byte_time <= q_item.now_ms;
                  end
                  st <= S_P0;
                end
              end
            endcase
          end
        end

        S_REFUSE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= mrtu_pkg::KIND_REFUSED;
            m_tlast  <= 1'b1;
            m_tdata  <= '0;
            st       <= S_IDLE;
          end
        end

        S_TX: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= mrtu_pkg::KIND_TX;
            m_tlast  <= (tx_k == 3'd7);
            m_tdata  <= {160'd0, req_byte};
            if (tx_k < 3'd6) begin
              crc <= mrtu_pkg::crc16_byte(crc, req_byte);
            end
            tx_k <= tx_k + 3'd1;
            if (tx_k == 3'd7) begin
              st <= S_IDLE;
            end
          end
        end

        S_P0: begin
          if (len == '0) begin
            st <= S_BUSY;
          end else begin
            off <= '0;
            st  <= S_A_REQ;
          end
        end
        S_A_REQ: st <= S_A_USE;
        S_A_USE: begin
          if (dout != slave_address) begin
            bad_seen <= 1'b1;
            off      <= LW'(1);
            st       <= S_RS_REQ;
          end else if (len < LW'(2)) begin
            st <= S_BUSY;
          end else begin
            off <= LW'(1);
            st  <= S_F_REQ;
          end
        end

        // Resync: look for the next slave-address byte after the frame head.
        S_RS_REQ: begin
          if (off >= len) begin
            len <= '0;
            st  <= S_BUSY;
          end else begin
            st <= S_RS_USE;
          end
        end
        S_RS_USE: begin
          if (dout == slave_address) begin
            base <= raddr;
            len  <= len - off;
            st   <= S_P0;
          end else begin
            off <= off + LW'(1);
            st  <= S_RS_REQ;
          end
        end

        S_F_REQ: st <= S_F_USE;
        S_F_USE: begin
          if (dout == mrtu_pkg::FN_EXCEPT) begin
            if (len < LW'(mrtu_pkg::EXC_LEN)) begin
              st <= S_BUSY;
            end else begin
              bad_seen <= 1'b1;
              off      <= LW'(1);
              st       <= S_RS_REQ;
            end
          end else if (dout != mrtu_pkg::FN_READ) begin
            bad_seen <= 1'b1;
            off      <= LW'(1);
            st       <= S_RS_REQ;
          end else if (len < LW'(3)) begin
            st <= S_BUSY;
          end else begin
            off <= LW'(2);
            st  <= S_C_REQ;
          end
        end
        S_C_REQ: st <= S_C_USE;
        S_C_USE: begin
          if (dout != mrtu_pkg::BYTE_COUNT) begin
            bad_seen <= 1'b1;
            off      <= LW'(1);
            st       <= S_RS_REQ;
          end else if (len < LW'(mrtu_pkg::RESP_LEN)) begin
            st <= S_BUSY;
          end else begin
            crc <= 16'hFFFF;
            off <= '0;
            st  <= S_K_REQ;
          end
        end

        // CRC walk over the body; register bytes are captured on the way.
        S_K_REQ: st <= S_K_USE;
        S_K_USE: begin
          crc <= mrtu_pkg::crc16_byte(crc, dout);
          if (off >= LW'(3)) begin
            regs <= {regs[119:0], dout};
          end
          off <= off + LW'(1);
          st  <= (off == LW'(mrtu_pkg::RESP_LEN - 3)) ? S_L_REQ : S_K_REQ;
        end
        S_L_REQ: st <= S_L_USE;
        S_L_USE: begin
          lo_byte <= dout;
          off     <= off + LW'(1);
          st      <= S_H_REQ;
        end
        S_H_REQ: st <= S_H_USE;
        S_H_USE: begin
          if ({dout, lo_byte} != crc) begin
            bad_seen <= 1'b1;
            off      <= LW'(1);
            st       <= S_RS_REQ;
          end else begin
            verdict <= exp_lbt ? (bad_seen ? mrtu_pkg::KIND_BAD : mrtu_pkg::KIND_TIMEOUT)
                               : mrtu_pkg::KIND_FRESH;
            st      <= S_VERD;
          end
        end

        S_BUSY: begin
          if (exp_now) begin
            verdict <= bad_seen ? mrtu_pkg::KIND_BAD : mrtu_pkg::KIND_TIMEOUT;
            st      <= S_VERD;
          end else begin
            st <= S_IDLE;
          end
        end

        S_VERD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= verdict;
            m_tlast  <= 1'b1;
            if (verdict == mrtu_pkg::KIND_FRESH) begin
              m_tdata <= {last_byte_time, regs[15:0], regs[31:16], regs[47:32], regs[63:48],
                          regs[79:64], regs[95:80], regs[111:96], regs[127:112], 8'h00};
            end else begin
              m_tdata <= '0;
            end
            awaiting <= 1'b0;
            len      <= '0;
            bad_seen <= 1'b0;
            st       <= S_IDLE;
          end
        end

        default: st <= S_IDLE;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(STORE_BYTES))
    else $error("frame length exceeds the store");

  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    base < AW'(STORE_BYTES) || STORE_BYTES == (1 << AW))
    else $error("frame base out of range");

  a_tx_open: assert property (@(posedge clk) disable iff (rst)
    st == S_TX |-> awaiting)
    else $error("request bytes sent with no open transaction");

  a_verdict_closes: assert property (@(posedge clk) disable iff (rst)
    (st == S_VERD && out_free) |=> (!awaiting && len == '0 && m_tvalid && m_tlast))
    else $error("verdict did not close the transaction");

  a_parse_open: assert property (@(posedge clk) disable iff (rst)
    (st == S_P0 || st == S_BUSY) |-> awaiting)
    else $error("parser running outside a transaction");

endmodule

[src/modbus_rtu_sensor_poll_master.sv]
// Modbus RTU poll master: read of 8 holding registers.
// Start: the request bytes, or the refusal, leave through the output register, one per cycle unless m_tready stalls it.
// Byte or time check: the parser reads the store through the address, function, count and CRC states, resyncing past
// frames that fail; a verdict comes once a reply passes its CRC check or once the deadline has passed.
// Items are handled one at a time behind a two-entry queue; a stalled result stalls the back.
// Synchronous reset restores control state, configuration and output valid; the frame store is not cleared.
module modbus_rtu_sensor_poll_master #(
  parameter int STORE_BYTES = mrtu_pkg::STORE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // rx_byte[7:0], now_ms[39:8]
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // tx_byte, x_tilt, y_tilt, z_tilt, sensor_status,
                                  // temperature, identity_word, firmware_word,
                                  // heartbeat_word, arrival_ms
  output logic [2:0]   m_tuser,   // kind[2:0]
  output logic         m_tlast
);

  logic            q_valid;
  logic            q_pop;
  mrtu_pkg::item_t q_item;

  mrtu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mrtu_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
